### src/log_record_replay_checker_defines.svh
// Assertion macros used by the checker file of the log replay checker.
// No dependencies.
`ifndef LOG_RECORD_REPLAY_CHECKER_DEFINES_SVH
`define LOG_RECORD_REPLAY_CHECKER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LRRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrrc: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define LRRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrrc: next-cycle check failed");

`endif

### src/lrrc_pkg.sv
// Types, codes, constants and the byte-wise CRC-32 function for the log
// replay checker. No dependencies.
package lrrc_pkg;

    localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES          = 32'hFFFF_FFFF;
    localparam logic [31:0] KEY_LIMIT_RESET   = 32'h0400_0000;
    localparam logic [31:0] VALUE_LIMIT_RESET = 32'h1000_0000;

    localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h49, 8'h51, 8'h4B};

    // op byte of a put record
    localparam logic [7:0] OP_PUT = 8'h01;

    localparam int ADDR_W    = 3;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 112;

    // result word layout
    localparam int OUT_DONE_BIT   = 8;
    localparam int OUT_PUT_BIT    = 9;
    localparam int OUT_KLEN_LSB   = 10;
    localparam int OUT_VLEN_LSB   = 42;
    localparam int OUT_COUNT_LSB  = 74;
    localparam int OUT_STATUS_LSB = 106;
    localparam int OUT_USED_W     = 109;

    // byte classes
    localparam logic [2:0] CLS_HEADER = 3'd0;
    localparam logic [2:0] CLS_OP     = 3'd1;
    localparam logic [2:0] CLS_KLEN   = 3'd2;
    localparam logic [2:0] CLS_VLEN   = 3'd3;
    localparam logic [2:0] CLS_KEY    = 3'd4;
    localparam logic [2:0] CLS_VALUE  = 3'd5;
    localparam logic [2:0] CLS_CRC    = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ST_CRC_BAD    = 3'd3;
    localparam logic [2:0] ST_TRUNCATED  = 3'd4;

    // register index bit in paddr
    localparam logic REG_MAX_KEY = 1'b0;
    localparam logic REG_MAX_VAL = 1'b1;

    typedef struct packed {
        logic [31:0] max_key;
        logic [31:0] max_val;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  echo_byte;
        logic [2:0]  byte_class;
        logic        record_done;
        logic        is_put;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic [31:0] record_count;
        logic [2:0]  status;
        logic        end_of_log;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### src/log_record_replay_checker.sv
// Key-value log replay checker, top level.
// Input byte stream on s_*, one result word per byte on m_*, length limits
// on an APB port (0x0 max key length, 0x4 max value length).
// Each accepted byte yields exactly one result word. s_tlast marks the last
// byte of the log. m_tuser carries the byte class, m_tlast the clean end.
// Each byte passes the input register, then the result register.
// Throughput: one byte per cycle while m_tready holds; the CRC update
// of a whole byte and the 32-bit length compares sit between those two
// registers.
// Both register stages advance together whenever the result register is
// empty or being taken; while the receiver stalls, one byte stays in the
// input register and s_tready drops only once both stages are full.
// Reset (synchronous, active low) returns to the header phase, clears the
// record count and error, empties both stages and restores the limits to
// 64 MiB keys and 256 MiB values. Errors are sticky until reset.
// Depends on lrrc_pkg, lrrc_cfg and lrrc_parser.
module log_record_replay_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lrrc_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  logic                             s_tlast,  // stream_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] echo_byte, [8] record_done, [9] is_put, [41:10] key_length,
    // [73:42] value_length, [105:74] record_count, [108:106] status
    output logic [lrrc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [2:0]                       m_tuser,  // [2:0] byte_class
    output logic                             m_tlast,  // end_of_log
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrrc_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import lrrc_pkg::*;

    t_cfg        cfg;
    t_result     res;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;
    logic        r_out_valid;
    t_result     r_out;
    logic        adv;
    logic        step;

    assign adv      = !r_out_valid || m_tready;
    assign step     = r_in_valid && adv;
    assign s_tready = !r_in_valid || adv;

    lrrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lrrc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata[7:0];
            r_in_end  <= s_tlast;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.byte_class;
    assign m_tlast  = r_out.end_of_log;
    assign m_tdata  = {
        (OUT_DATA_W - OUT_USED_W)'(0),
        r_out.status,
        r_out.record_count,
        r_out.value_length,
        r_out.key_length,
        r_out.is_put,
        r_out.record_done,
        r_out.echo_byte
    };

endmodule

### src/lrrc_cfg.sv
// APB register file for the key and value length limits.
// Depends on lrrc_pkg.
module lrrc_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrrc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lrrc_pkg::t_cfg             o_cfg
);
    import lrrc_pkg::*;

    logic [31:0] r_max_key;
    logic [31:0] r_max_val;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_VAL) ? r_max_val : r_max_key;
    assign o_cfg  = '{max_key: r_max_key, max_val: r_max_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_key <= KEY_LIMIT_RESET;
            r_max_val <= VALUE_LIMIT_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_MAX_VAL) begin
                r_max_val <= pwdata;
            end else begin
                r_max_key <= pwdata;
            end
        end
    end

endmodule

### src/lrrc_parser.sv
// Record parser: phase state, length assembly, CRC-32 and error tracking.
// Computes one result per stepped byte. Depends on lrrc_pkg.
module lrrc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    input  lrrc_pkg::t_cfg    i_cfg,
    output lrrc_pkg::t_result o_res
);
    import lrrc_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_OP     = 3'd1,
        PH_KLEN   = 3'd2,
        PH_VLEN   = 3'd3,
        PH_KEY    = 3'd4,
        PH_VALUE  = 3'd5,
        PH_CRC    = 3'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_fc, n_fc;
    logic [7:0]  r_op, n_op;
    logic [31:0] r_klen, n_klen;
    logic [31:0] r_vlen, n_vlen;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_stored, n_stored;
    logic [31:0] r_count, n_count;
    logic [2:0]  r_err, n_err;

    logic [31:0] fc_inc;
    logic [31:0] b_shift;
    logic [31:0] crc_upd;
    logic [2:0]  cls;
    logic [2:0]  err;
    logic        done;
    logic        clean;
    logic        eol;

    assign fc_inc  = r_fc + 32'd1;
    assign b_shift = {24'd0, i_byte} << {r_fc[1:0], 3'b000};
    assign crc_upd = crc_byte(r_crc, i_byte);

    always_comb begin
        n_phase  = r_phase;
        n_fc     = r_fc;
        n_op     = r_op;
        n_klen   = r_klen;
        n_vlen   = r_vlen;
        n_crc    = r_crc;
        n_stored = r_stored;
        n_count  = r_count;
        n_err    = r_err;
        cls      = CLS_HEADER;
        err      = ST_OK;
        done     = 1'b0;
        clean    = 1'b0;
        eol      = 1'b0;
        if (r_err == ST_OK) begin
            cls = r_phase;
            case (r_phase)
                PH_HEADER: begin
                    if (r_fc < 32'd4 && i_byte != MAGIC[r_fc[1:0]]) begin
                        err = ST_BAD_HEADER;
                    end
                    n_fc = fc_inc;
                    if (fc_inc >= 32'd8) begin
                        n_phase = PH_OP;
                        n_fc    = '0;
                        clean   = 1'b1;
                    end
                end
                PH_KLEN: begin
                    n_crc  = crc_upd;
                    n_klen = r_klen | b_shift;
                    n_fc   = fc_inc;
                    if (fc_inc >= 32'd4) begin
                        n_phase = PH_VLEN;
                        n_fc    = '0;
                    end
                end
                PH_VLEN: begin
                    n_crc  = crc_upd;
                    n_vlen = r_vlen | b_shift;
                    n_fc   = fc_inc;
                    if (fc_inc >= 32'd4) begin
                        n_fc = '0;
                        if (r_klen > i_cfg.max_key || n_vlen > i_cfg.max_val) begin
                            err = ST_TOO_LARGE;
                        end else if (r_klen != '0) begin
                            n_phase = PH_KEY;
                        end else if (n_vlen != '0) begin
                            n_phase = PH_VALUE;
                        end else begin
                            n_phase = PH_CRC;
                        end
                    end
                end
                PH_KEY: begin
                    n_crc = crc_upd;
                    n_fc  = fc_inc;
                    if (fc_inc >= r_klen) begin
                        n_fc    = '0;
                        n_phase = (r_vlen != '0) ? PH_VALUE : PH_CRC;
                    end
                end
                PH_VALUE: begin
                    n_crc = crc_upd;
                    n_fc  = fc_inc;
                    if (fc_inc >= r_vlen) begin
                        n_fc    = '0;
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    n_stored = r_stored | b_shift;
                    n_fc     = fc_inc;
                    if (fc_inc >= 32'd4) begin
                        n_fc = '0;
                        if ((r_crc ^ ALL_ONES) == n_stored) begin
                            done    = 1'b1;
                            clean   = 1'b1;
                            n_phase = PH_OP;
                            if (r_count != ALL_ONES) begin
                                n_count = r_count + 32'd1;
                            end
                        end else begin
                            err = ST_CRC_BAD;
                        end
                    end
                end
                default: begin
                    // op byte, also taken for the unused phase code
                    cls      = CLS_OP;
                    n_op     = i_byte;
                    n_crc    = crc_byte(ALL_ONES, i_byte);
                    n_klen   = '0;
                    n_vlen   = '0;
                    n_stored = '0;
                    n_fc     = '0;
                    n_phase  = PH_KLEN;
                end
            endcase
            if (err != ST_OK) begin
                n_err = err;
                done  = 1'b0;
            end else if (i_end) begin
                if (clean) begin
                    eol = 1'b1;
                end else begin
                    n_err = ST_TRUNCATED;
                end
            end
        end
    end

    assign o_res = '{
        echo_byte:    i_byte,
        byte_class:   cls,
        record_done:  done,
        is_put:       (n_op == OP_PUT),
        key_length:   n_klen,
        value_length: n_vlen,
        record_count: n_count,
        status:       n_err,
        end_of_log:   eol
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_fc     <= '0;
            r_op     <= '0;
            r_klen   <= '0;
            r_vlen   <= '0;
            r_crc    <= ALL_ONES;
            r_stored <= '0;
            r_count  <= '0;
            r_err    <= ST_OK;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_op     <= n_op;
            r_klen   <= n_klen;
            r_vlen   <= n_vlen;
            r_crc    <= n_crc;
            r_stored <= n_stored;
            r_count  <= n_count;
            r_err    <= n_err;
        end
    end

endmodule

### src/lrrc_checker.sv
// Port-level assertions for the log replay checker, bound to the top level.
// Depends on lrrc_pkg and log_record_replay_checker_defines.svh.
`include "log_record_replay_checker_defines.svh"

module lrrc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lrrc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [2:0]                       m_tuser,
    input  logic                             m_tlast
);
    import lrrc_pkg::*;

    logic [2:0] status;
    logic       st_ok;
    logic       done;
    logic       stall;
    logic       err_seen;
    logic       at_bound;

    assign status   = m_tdata[OUT_STATUS_LSB +: 3];
    assign st_ok    = (status == ST_OK);
    assign done     = m_tdata[OUT_DONE_BIT];
    assign stall    = m_tvalid && !m_tready;
    assign err_seen = m_tvalid && !st_ok;
    assign at_bound = m_tuser inside {CLS_CRC, CLS_HEADER};

    `LRRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, m_tvalid && $stable(m_tdata))
    `LRRC_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, err_seen, !m_tvalid || status == $past(status))
    `LRRC_ASSERT_IMPL(a_done_ok, i_clk, i_rst_n, m_tvalid && done, st_ok && m_tuser == CLS_CRC)
    `LRRC_ASSERT_IMPL(a_eol_ok, i_clk, i_rst_n, m_tvalid && m_tlast, st_ok && at_bound)
    `LRRC_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, !s_tready, stall)

endmodule

bind log_record_replay_checker lrrc_checker u_lrrc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
